// ===== src/ofp_pkg.sv =====
// shared types and constants for the orientation frame parser
`default_nettype none
package ofp_pkg;

    localparam logic [7:0] HDR_FIRST = 8'h46;
    localparam logic [7:0] HDR_REST  = 8'h45;

    localparam int PAYLOAD_LEN = 20;
    localparam int POS_W       = 5;
    localparam int IDX_W       = 5;

    localparam logic [POS_W-1:0] HDR_LEN  = 5'd3;
    localparam logic [POS_W-1:0] LAST_POS = 5'd22;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [15:0] ROUND_BIAS  = 16'd5;
    localparam logic [15:0] RECIP_TEN   = 16'd52429;
    localparam int          RECIP_SHIFT = 19;
    localparam int          ANGLE_W     = 13;

    localparam int QUEUE_DEPTH = 2;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] word_t;

    // one complete frame, already split into words
    typedef struct packed {
        word_t [2:0] raw;
        word_t [2:0] offset;
        word_t [2:0] value;
        word_t       heading;
    } frame_t;

endpackage
`default_nettype wire

// ===== src/orientation_frame_parser.sv =====
// Orientation frame parser. One sensor byte is taken per transfer, and a new byte
// can be taken every cycle. The front hunts for the header "FEE", restarting a
// frame whenever it sees one, and stores the next 20 payload bytes. When the last
// payload byte arrives the whole frame goes into a two-entry queue; the back end
// then gives three results, x, y and z, in that order, with last_of_frame set
// on z; a frame passes the queue entry, the multiply stage and the output stage
// in turn. The rate of the back end is one result per cycle while out_ready is
// high, set by its two-stage multiply and output pipeline; input stalls only
// when both queue entries hold frames. Bytes outside a frame give no result.
`default_nettype none
module orientation_frame_parser (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [7:0]   rx_byte,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [1:0]        axis_index,
    output logic [15:0]       raw_word,
    output logic [15:0]       offset_word,
    output logic signed [15:0] axis_value,
    output logic signed [12:0] rounded_angle,
    output logic [15:0]       heading_word,
    output logic              last_of_frame
);
    import ofp_pkg::*;

    logic   push_valid, push_ready;
    frame_t push_data;
    logic   pop_valid, pop_ready;
    frame_t pop_data;

    ofp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    ofp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ofp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_valid   (pop_valid),
        .frame_ready   (pop_ready),
        .frame         (pop_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .axis_index    (axis_index),
        .raw_word      (raw_word),
        .offset_word   (offset_word),
        .axis_value    (axis_value),
        .rounded_angle (rounded_angle),
        .heading_word  (heading_word),
        .last_of_frame (last_of_frame)
    );

endmodule
`default_nettype wire

// ===== src/ofp_front.sv =====
// byte hunter: header search, payload capture and frame hand-off
`default_nettype none
module ofp_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire ofp_pkg::byte_t rx_byte,
    output logic               push_valid,
    input  wire logic          push_ready,
    output ofp_pkg::frame_t    push_data
);
    import ofp_pkg::*;

    byte_t            win_reg [2];
    logic             in_frame_reg, in_frame_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    byte_t            payload_reg [PAYLOAD_LEN];

    logic             accept;
    logic             hdr_hit;
    logic             closing;
    logic             store_en;
    logic [IDX_W-1:0] store_idx;
    byte_t            fb [PAYLOAD_LEN];

    assign in_ready  = push_ready;
    assign accept    = in_valid && in_ready;
    assign hdr_hit   = (win_reg[1] == HDR_FIRST) && (win_reg[0] == HDR_REST)
                       && (rx_byte == HDR_REST);
    assign store_en  = accept && !hdr_hit && in_frame_reg;
    assign closing   = store_en && (pos_reg == LAST_POS);
    assign store_idx = pos_reg - HDR_LEN;

    assign push_valid = closing;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        if (accept && hdr_hit)
        begin
            in_frame_next = 1'b1;
            pos_next      = HDR_LEN;
        end
        else if (store_en)
        begin
            pos_next = pos_reg + 5'd1;
            if (closing)
                in_frame_next = 1'b0;
        end
    end

    // the closing byte goes straight into the frame, the store has not caught it yet
    always_comb
    begin
        for (int i = 0; i < PAYLOAD_LEN - 1; i++)
            fb[i] = payload_reg[i];
        fb[PAYLOAD_LEN-1] = rx_byte;
        for (int a = 0; a < 3; a++)
        begin
            push_data.raw[a]    = {fb[2*a],      fb[2*a + 1]};
            push_data.offset[a] = {fb[6 + 2*a],  fb[7 + 2*a]};
            push_data.value[a]  = {fb[12 + 2*a], fb[13 + 2*a]};
        end
        push_data.heading = {fb[18], fb[19]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg[0]   <= '0;
            win_reg[1]   <= '0;
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                win_reg[1] <= win_reg[0];
                win_reg[0] <= rx_byte;
            end
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
            payload_reg[store_idx] <= rx_byte;
    end

endmodule
`default_nettype wire

// ===== src/ofp_queue.sv =====
// short frame queue between the byte hunter and the result stage
`default_nettype none
module ofp_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire ofp_pkg::frame_t push_data,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output ofp_pkg::frame_t      pop_data
);
    import ofp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    frame_t           entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

// ===== src/ofp_back.sv =====
// result stage: walks the three axes of a frame and rounds the angle
`default_nettype none
module ofp_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            frame_valid,
    output logic                 frame_ready,
    input  wire ofp_pkg::frame_t frame,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [1:0]           axis_index,
    output logic [15:0]          raw_word,
    output logic [15:0]          offset_word,
    output logic signed [15:0]   axis_value,
    output logic signed [12:0]   rounded_angle,
    output logic [15:0]          heading_word,
    output logic                 last_of_frame
);
    import ofp_pkg::*;

    logic [1:0]  axis_reg, axis_next;
    logic        issue, b_adv, c_load;
    logic        b_valid_reg, b_valid_next;
    logic        c_valid_reg, c_valid_next;

    word_t       sel_value;
    logic        sel_sign;
    word_t       mag;
    word_t       biased;
    logic [31:0] prod;

    // multiply stage
    logic [1:0]         b_axis_reg;
    word_t              b_raw_reg, b_offset_reg, b_value_reg, b_heading_reg;
    logic               b_sign_reg;
    logic [ANGLE_W-1:0] b_quo_reg;

    // output stage
    logic [1:0]         c_axis_reg;
    word_t              c_raw_reg, c_offset_reg, c_value_reg, c_heading_reg;
    logic [ANGLE_W-1:0] c_angle_reg;

    assign c_load      = !c_valid_reg || out_ready;
    assign b_adv       = c_load;
    assign issue       = frame_valid && (!b_valid_reg || b_adv);
    assign frame_ready = issue && (axis_reg == AXIS_Z);

    assign sel_value = frame.value[axis_reg];
    assign sel_sign  = sel_value[15];
    assign mag       = sel_sign ? (~sel_value + 16'd1) : sel_value;
    // |v| + 5 then divide by ten through the reciprocal, exact below 2^16
    assign biased    = mag + ROUND_BIAS;
    assign prod      = biased * RECIP_TEN;

    always_comb
    begin
        axis_next    = axis_reg;
        b_valid_next = b_valid_reg;
        c_valid_next = c_valid_reg;
        if (issue)
            axis_next = (axis_reg == AXIS_Z) ? AXIS_X : axis_reg + 2'd1;
        if (issue)
            b_valid_next = 1'b1;
        else if (b_adv)
            b_valid_next = 1'b0;
        if (c_load)
            c_valid_next = b_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg    <= AXIS_X;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            axis_reg    <= axis_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_axis_reg    <= axis_reg;
            b_raw_reg     <= frame.raw[axis_reg];
            b_offset_reg  <= frame.offset[axis_reg];
            b_value_reg   <= sel_value;
            b_heading_reg <= frame.heading;
            b_sign_reg    <= sel_sign;
            b_quo_reg     <= prod[RECIP_SHIFT +: ANGLE_W];
        end
        if (c_load && b_valid_reg)
        begin
            c_axis_reg    <= b_axis_reg;
            c_raw_reg     <= b_raw_reg;
            c_offset_reg  <= b_offset_reg;
            c_value_reg   <= b_value_reg;
            c_heading_reg <= b_heading_reg;
            c_angle_reg   <= b_sign_reg ? (~b_quo_reg + 13'd1) : b_quo_reg;
        end
    end

    assign out_valid     = c_valid_reg;
    assign axis_index    = c_axis_reg;
    assign raw_word      = c_raw_reg;
    assign offset_word   = c_offset_reg;
    assign axis_value    = c_value_reg;
    assign rounded_angle = c_angle_reg;
    assign heading_word  = c_heading_reg;
    assign last_of_frame = (c_axis_reg == AXIS_Z);

endmodule
`default_nettype wire

// ===== src/ofp_checker.sv =====
// port-level checks for the orientation frame parser
`default_nettype none
module ofp_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic [7:0]         rx_byte,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [1:0]         axis_index,
    input wire logic [15:0]        raw_word,
    input wire logic [15:0]        offset_word,
    input wire logic signed [15:0] axis_value,
    input wire logic signed [12:0] rounded_angle,
    input wire logic [15:0]        heading_word,
    input wire logic               last_of_frame
);
    import ofp_pkg::*;

    a_last_on_z: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_of_frame == (axis_index == AXIS_Z)))
        else $error("last flag does not match the z axis");

    // the y result of a frame follows its x result without a gap
    a_y_follows_x: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && axis_index == AXIS_X
        |=> out_valid && axis_index == AXIS_Y && heading_word == $past(heading_word))
        else $error("y result missing after x transfer");

    a_angle_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rounded_angle[12] |-> axis_value[15])
        else $error("negative angle from a non-negative reading");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready
        |=> out_valid && $stable(axis_value) && $stable(axis_index))
        else $error("result changed while stalled");

endmodule

bind orientation_frame_parser ofp_checker u_ofp_checker (.*);
`default_nettype wire
